@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DTA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define DTA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DTA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DTA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/dta_pkg.sv @@
`timescale 1ns / 1ps

package dta_pkg;

   localparam int NUM_STAGES   = 10;
   localparam int MONTH_STEPS  = 3;
   localparam int FIRST_MSTEP  = NUM_STAGES - MONTH_STEPS;

   localparam logic [16:0] SECS_PER_MIN  = 17'd60;
   localparam logic [16:0] MINS_PER_HOUR = 17'd60;
   localparam logic [16:0] HOURS_PER_DAY = 17'd24;
   localparam logic [6:0]  YEARS_WRAP    = 7'd100;
   localparam logic [6:0]  LAST_YEAR     = 7'd99;
   localparam logic [3:0]  JANUARY       = 4'd1;
   localparam logic [3:0]  FEBRUARY      = 4'd2;
   localparam logic [3:0]  APRIL         = 4'd4;
   localparam logic [3:0]  JUNE          = 4'd6;
   localparam logic [3:0]  SEPTEMBER     = 4'd9;
   localparam logic [3:0]  NOVEMBER      = 4'd11;
   localparam logic [3:0]  DECEMBER      = 4'd12;
   localparam logic [4:0]  FIRST_DAY     = 5'd1;

   // floor(t/60) = (t * 34953) >> 21 for t < 74898
   localparam logic [16:0] MIN_RECIP     = 17'd34953;
   localparam int          MIN_SHIFT     = 21;
   // floor(t/24) = (t * 43691) >> 20 for t < 131072
   localparam logic [16:0] HOUR_RECIP    = 17'd43691;
   localparam int          HOUR_SHIFT    = 20;

   typedef struct packed {
      logic [6:0]  start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [4:0]  start_hour;
      logic [5:0]  start_minute;
      logic [5:0]  start_second;
      logic [15:0] add_minutes;
      logic [15:0] add_seconds;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  end_year;
      logic [3:0]  end_month;
      logic [4:0]  end_day;
      logic [4:0]  end_hour;
      logic [5:0]  end_minute;
      logic [5:0]  end_second;
      logic        year_wrapped;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        wrapped;
      logic [15:0] add_min;
      logic [16:0] t;
      logic [10:0] q;
   } pipe_type;

   // years 2000..2099: only multiples of four are leap (2000 is divisible by 400)
   function automatic logic [6:0] days_in_month(logic [6:0] year, logic [3:0] month);
      logic [6:0] md;
      md = 7'd31;
      if (month == FEBRUARY) begin
         md = (year[1:0] == 2'b00) ? 7'd29 : 7'd28;
      end else if (month == APRIL || month == JUNE || month == SEPTEMBER ||
                   month == NOVEMBER) begin
         md = 7'd30;
      end
      return md;
   endfunction

   function automatic pipe_type month_step(pipe_type p);
      pipe_type   r;
      logic [6:0] md;
      r  = p;
      md = days_in_month(p.year, p.month);
      if (p.day > md) begin
         r.day = p.day - md;
         if (p.month == DECEMBER) begin
            r.month = JANUARY;
            if (p.year == LAST_YEAR) begin
               r.year    = '0;
               r.wrapped = 1'b1;
            end else begin
               r.year = p.year + 7'd1;
            end
         end else begin
            r.month = p.month + 4'd1;
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/dta_req_if.sv @@
`timescale 1ns / 1ps

interface dta_req_if;
   import dta_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/dta_rsp_if.sv @@
`timescale 1ns / 1ps

interface dta_rsp_if;
   import dta_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/date_time_add_offset.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Adds an offset in minutes and seconds to a date-time (year 0..99 from 2000,
// month, day, hour, minute, second) and returns the later date-time with
// Gregorian month lengths; a year past 99 wraps to 0 and sets year_wrapped.
// The block is a ten-stage pipeline: one item enters per cycle unless
// backpressure on rsp holds stage 0, and its result leaves from the last stage.
// The depth is one input stage, the two divide-by-60 and one divide-by-24
// reciprocal multiplies (two stages each) and three month-carry stages.
// Backpressure on rsp stalls each stage only as far as needed.
module date_time_add_offset (
   input logic     clock,
   input logic     reset,
   dta_req_if.sink   req_chan,
   dta_rsp_if.source rsp_chan
);
   import dta_pkg::*;

   pipe_type              pipe_ff [NUM_STAGES];
   pipe_type              pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_rdy;

   logic [33:0] min_prod_a;
   logic [33:0] min_prod_b;
   logic [26:0] hour_prod;
   logic [16:0] sec_rem;
   logic [16:0] min_rem;
   logic [16:0] hour_rem;

   assign min_prod_a = 34'(pipe_ff[0].t) * 34'(MIN_RECIP);
   assign min_prod_b = 34'(pipe_ff[2].t) * 34'(MIN_RECIP);
   assign hour_prod  = 27'(pipe_ff[4].t[10:0]) * 27'(HOUR_RECIP);
   assign sec_rem    = pipe_ff[1].t - 17'(pipe_ff[1].q) * SECS_PER_MIN;
   assign min_rem    = pipe_ff[3].t - 17'(pipe_ff[3].q) * MINS_PER_HOUR;
   assign hour_rem   = pipe_ff[5].t - 17'(pipe_ff[5].q) * HOURS_PER_DAY;

   always_comb begin
      // stage 0: clean up the start fields, add the seconds
      pipe_in[0]         = '0;
      pipe_in[0].year    = (req_chan.item.start_year >= YEARS_WRAP) ?
                           req_chan.item.start_year - YEARS_WRAP : req_chan.item.start_year;
      pipe_in[0].month   = req_chan.item.start_month;
      if (req_chan.item.start_month == 4'd0) begin
         pipe_in[0].month = JANUARY;
      end else if (req_chan.item.start_month > DECEMBER) begin
         pipe_in[0].month = DECEMBER;
      end
      pipe_in[0].day     = (req_chan.item.start_day == 5'd0) ?
                           7'(FIRST_DAY) : 7'(req_chan.item.start_day);
      pipe_in[0].hour    = req_chan.item.start_hour;
      pipe_in[0].minute  = req_chan.item.start_minute;
      pipe_in[0].add_min = req_chan.item.add_minutes;
      pipe_in[0].t       = 17'(req_chan.item.start_second) + 17'(req_chan.item.add_seconds);

      // stage 1: minute carry from seconds
      pipe_in[1]   = pipe_ff[0];
      pipe_in[1].q = min_prod_a[MIN_SHIFT +: 11];

      // stage 2: seconds result, sum the minutes
      pipe_in[2]        = pipe_ff[1];
      pipe_in[2].second = sec_rem[5:0];
      pipe_in[2].t      = 17'(pipe_ff[1].minute) + 17'(pipe_ff[1].add_min) +
                          17'(pipe_ff[1].q);

      // stage 3: hour carry
      pipe_in[3]   = pipe_ff[2];
      pipe_in[3].q = min_prod_b[MIN_SHIFT +: 11];

      // stage 4: minutes result, sum the hours
      pipe_in[4]        = pipe_ff[3];
      pipe_in[4].minute = min_rem[5:0];
      pipe_in[4].t      = 17'(pipe_ff[3].hour) + 17'(pipe_ff[3].q);

      // stage 5: day carry
      pipe_in[5]   = pipe_ff[4];
      pipe_in[5].q = 11'(hour_prod[HOUR_SHIFT +: 7]);

      // stage 6: hours result, add the days
      pipe_in[6]      = pipe_ff[5];
      pipe_in[6].hour = hour_rem[4:0];
      pipe_in[6].day  = pipe_ff[5].day + 7'(pipe_ff[5].q);

      // month carry, one month per stage
      for (int s = FIRST_MSTEP; s < NUM_STAGES; s++) begin
         pipe_in[s] = month_step(pipe_ff[s-1]);
      end
   end

   always_comb begin
      stage_rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_rdy[s] = !valid_ff[s] || stage_rdy[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_rdy[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (stage_rdy[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (stage_rdy[s]) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   assign req_chan.ready              = stage_rdy[0];
   assign rsp_chan.valid              = valid_ff[NUM_STAGES-1];
   assign rsp_chan.item.end_year      = pipe_ff[NUM_STAGES-1].year;
   assign rsp_chan.item.end_month     = pipe_ff[NUM_STAGES-1].month;
   assign rsp_chan.item.end_day       = pipe_ff[NUM_STAGES-1].day[4:0];
   assign rsp_chan.item.end_hour      = pipe_ff[NUM_STAGES-1].hour;
   assign rsp_chan.item.end_minute    = pipe_ff[NUM_STAGES-1].minute;
   assign rsp_chan.item.end_second    = pipe_ff[NUM_STAGES-1].second;
   assign rsp_chan.item.year_wrapped  = pipe_ff[NUM_STAGES-1].wrapped;

   `DTA_ASSERT_IMP(a_date_range, clock, reset, rsp_chan.valid,
      (pipe_ff[NUM_STAGES-1].month >= JANUARY && pipe_ff[NUM_STAGES-1].month <= DECEMBER &&
       pipe_ff[NUM_STAGES-1].day >= 7'(FIRST_DAY) &&
       pipe_ff[NUM_STAGES-1].day <= days_in_month(pipe_ff[NUM_STAGES-1].year,
                                                  pipe_ff[NUM_STAGES-1].month) &&
       pipe_ff[NUM_STAGES-1].year <= LAST_YEAR))
   `DTA_ASSERT_IMP(a_time_range, clock, reset, rsp_chan.valid,
      (pipe_ff[NUM_STAGES-1].hour < 5'(HOURS_PER_DAY) &&
       pipe_ff[NUM_STAGES-1].minute < 6'(MINS_PER_HOUR) &&
       pipe_ff[NUM_STAGES-1].second < 6'(SECS_PER_MIN)))
   `DTA_ASSERT_IMP(a_mid_day_carry, clock, reset, valid_ff[6], (pipe_ff[6].day <= 7'd78))
   `DTA_ASSERT_NEXT(a_stall_holds, clock, reset, (valid_ff[3] && !stage_rdy[3]),
      (valid_ff[3] && $stable(pipe_ff[3])))

endmodule

@@ bench/tb_date_time_add_offset.sv @@
`timescale 1ns / 1ps

module tb_date_time_add_offset;
   import dta_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_ITEMS = 200;

   logic clock;
   logic reset;

   dta_req_if req_chan ();
   dta_rsp_if rsp_chan ();

   date_time_add_offset dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   rsp_item_type pending_times[$];
   int           time_mismatches;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned month_length(int unsigned yr, int unsigned mon);
      int unsigned full;
      bit          leap;
      full = 2000 + yr;
      leap = (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
      if (mon == FEBRUARY) begin
         return leap ? 29 : 28;
      end
      if (mon == APRIL || mon == JUNE || mon == SEPTEMBER || mon == NOVEMBER) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic rsp_item_type predict_later_time(req_item_type r);
      rsp_item_type res;
      int unsigned  yr, mon, dy, hr, mn, sc, total, carry;
      bit           wrapped;
      yr      = r.start_year % 100;
      mon     = r.start_month;
      dy      = r.start_day;
      hr      = r.start_hour;
      mn      = r.start_minute;
      sc      = r.start_second;
      wrapped = 1'b0;
      if (mon == 0) mon = 1;
      if (mon > 12) mon = 12;
      if (dy == 0) dy = 1;
      total = sc + r.add_seconds;
      sc    = total % 60;
      carry = total / 60;
      total = mn + r.add_minutes + carry;
      mn    = total % 60;
      carry = total / 60;
      total = hr + carry;
      hr    = total % 24;
      dy    = dy + total / 24;
      while (dy > month_length(yr, mon)) begin
         dy  = dy - month_length(yr, mon);
         mon = mon + 1;
         if (mon > 12) begin
            mon = 1;
            yr  = yr + 1;
            if (yr > 99) begin
               yr      = 0;
               wrapped = 1'b1;
            end
         end
      end
      res.end_year     = yr[6:0];
      res.end_month    = mon[3:0];
      res.end_day      = dy[4:0];
      res.end_hour     = hr[4:0];
      res.end_minute   = mn[5:0];
      res.end_second   = sc[5:0];
      res.year_wrapped = wrapped;
      return res;
   endfunction

   function automatic req_item_type make_item(int yr, int mon, int dy, int hr, int mn,
                                              int sc, int add_m, int add_s);
      req_item_type it;
      it.start_year   = yr[6:0];
      it.start_month  = mon[3:0];
      it.start_day    = dy[4:0];
      it.start_hour   = hr[4:0];
      it.start_minute = mn[5:0];
      it.start_second = sc[5:0];
      it.add_minutes  = add_m[15:0];
      it.add_seconds  = add_s[15:0];
      return it;
   endfunction

   function automatic int random_offset();
      case ($urandom_range(3))
         0: return $urandom_range(59);
         1: return $urandom_range(1440);
         2: return $urandom_range(65535);
         default: return $urandom_range(65535, 60000);
      endcase
   endfunction

   function automatic req_item_type random_item();
      int yr, mon;
      if ($urandom_range(9) == 0) begin
         // out-of-range noise over the full field widths
         return make_item($urandom_range(127), $urandom_range(15), $urandom_range(31),
                          $urandom_range(31), $urandom_range(63), $urandom_range(63),
                          $urandom_range(65535), $urandom_range(65535));
      end
      if ($urandom_range(7) == 0) begin
         yr  = 99;
         mon = $urandom_range(12, 11);
      end else begin
         yr  = $urandom_range(99);
         mon = $urandom_range(12, 1);
      end
      return make_item(yr, mon, $urandom_range(month_length(yr, mon), 1),
                       $urandom_range(23), $urandom_range(59), $urandom_range(59),
                       random_offset(), random_offset());
   endfunction

   // called and returns at a falling edge; valid stays high between back-to-back items
   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.item  <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_times.push_back(predict_later_time(it));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want, got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.item;
         if (pending_times.size() == 0) begin
            time_mismatches++;
            if (time_mismatches <= 10) begin
               $display("unexpected result %0d/%0d/%0d %0d:%0d:%0d wrap=%0d",
                        got.end_year, got.end_month, got.end_day, got.end_hour,
                        got.end_minute, got.end_second, got.year_wrapped);
            end
         end else begin
            want = pending_times.pop_front();
            if (got.end_year !== want.end_year || got.end_month !== want.end_month ||
                got.end_day !== want.end_day || got.end_hour !== want.end_hour ||
                got.end_minute !== want.end_minute || got.end_second !== want.end_second ||
                got.year_wrapped !== want.year_wrapped) begin
               time_mismatches++;
               if (time_mismatches <= 10) begin
                  $display("mismatch exp %0d/%0d/%0d %0d:%0d:%0d wrap=%0d",
                           want.end_year, want.end_month, want.end_day, want.end_hour,
                           want.end_minute, want.end_second, want.year_wrapped,
                           " got %0d/%0d/%0d %0d:%0d:%0d wrap=%0d",
                           got.end_year, got.end_month, got.end_day, got.end_hour,
                           got.end_minute, got.end_second, got.year_wrapped);
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic test_field_extremes();
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(127, 15, 31, 31, 63, 63, 65535, 65535));
      send_item(make_item(99, 12, 31, 23, 59, 59, 0, 0));
      send_item(make_item(99, 12, 31, 23, 59, 59, 65535, 65535));
      send_item(make_item(0, 1, 1, 0, 0, 0, 65535, 0));
   endtask

   task automatic test_input_clamping();
      send_item(make_item(100, 6, 15, 12, 30, 30, 10, 10));
      send_item(make_item(127, 3, 1, 0, 0, 0, 0, 0));
      send_item(make_item(20, 0, 31, 23, 59, 59, 0, 1));
      send_item(make_item(20, 13, 31, 23, 59, 59, 0, 1));
      send_item(make_item(21, 15, 10, 5, 5, 5, 0, 0));
      send_item(make_item(22, 7, 0, 8, 0, 0, 0, 0));
      send_item(make_item(23, 4, 31, 0, 0, 0, 0, 0));
      send_item(make_item(23, 2, 31, 10, 0, 0, 0, 0));
      send_item(make_item(24, 5, 20, 31, 63, 63, 0, 0));
   endtask

   task automatic test_leap_years();
      send_item(make_item(24, 2, 28, 23, 59, 59, 0, 1));
      send_item(make_item(23, 2, 28, 23, 59, 59, 0, 1));
      send_item(make_item(0, 2, 28, 0, 0, 0, 1440, 0));
      send_item(make_item(96, 2, 29, 12, 0, 0, 1440, 0));
   endtask

   task automatic test_year_wrap();
      send_item(make_item(99, 12, 31, 23, 59, 59, 0, 1));
      send_item(make_item(98, 12, 31, 23, 59, 59, 0, 1));
      send_item(make_item(99, 11, 20, 6, 0, 0, 65535, 0));
   endtask

   task automatic test_random_offsets(input int count);
      repeat (count) send_item(random_item());
   endtask

   initial begin
      time_mismatches = 0;
      send_idle_pct   = 17;
      recv_idle_pct   = 65;
      reset           = 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.item   <= '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_field_extremes();
      test_input_clamping();
      test_leap_years();
      test_year_wrap();
      test_random_offsets(RANDOM_ITEMS);
      send_idle_pct = 65;
      recv_idle_pct = 17;
      test_random_offsets(RANDOM_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_offsets(RANDOM_ITEMS);

      req_chan.valid <= 1'b0;
      while (pending_times.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (time_mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dta_pkg.sv
rtl/dta_req_if.sv
rtl/dta_rsp_if.sv
rtl/date_time_add_offset.sv
bench/tb_date_time_add_offset.sv
